[hw/rtl/segment_remapped_eeprom_store_unit_assert.svh]
// ----------------------------------------------------------------------------
// segment remapped store assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SEGMENT_REMAPPED_EEPROM_STORE_UNIT_ASSERT_SVH
`define SEGMENT_REMAPPED_EEPROM_STORE_UNIT_ASSERT_SVH

// same-cycle implication
`define SRES_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sres_pkg.sv]
// ----------------------------------------------------------------------------
// sres_pkg
// types, codes and defaults for the segment remapped byte store
// ----------------------------------------------------------------------------
package sres_pkg;

  localparam int MEM_BYTES_DEF    = 1024;
  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 9;

  typedef enum logic [2:0] {
    OP_RD_BYTE = 3'd0,
    OP_RD_WORD = 3'd1,
    OP_WR_BYTE = 3'd2,
    OP_WR_WORD = 3'd3,
    OP_LOAD    = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRANSLATE_ENABLE = 4'd0,
    CFG_ENTRY_COUNT      = 4'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_ACCESS,
    ST_RD0,
    ST_RD1,
    ST_WR1,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic [7:0]  entry_index;
    logic [15:0] entry_src_base;
    logic [15:0] entry_dst_base;
    logic [15:0] entry_len;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] len;
  } seg_t;

  // read data returned when an access is refused
  function automatic logic [15:0] fail_rdata(op_t op);
    logic [15:0] r;
    case (op)
      OP_RD_BYTE: r = 16'h00ff;
      OP_RD_WORD: r = 16'hffff;
      default:    r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/segment_remapped_eeprom_store_unit.sv]
// ----------------------------------------------------------------------------
// segment_remapped_eeprom_store_unit
// byte store behind a sorted segment remapper, one operation per command
// ----------------------------------------------------------------------------
// channel  direction  ports                          transfer
// in       input      start, busy, in_data           start high, busy low
// out      output     out_valid, out_data            one-cycle strobe
// cfg      input      cfg_valid, cfg_ready, cfg_*    valid and ready high
//
// after reset the store is erased by a pass over all MEM_BYTES bytes; busy is
// raised once a command is accepted and held through the strobe. an access
// walks the table one entry at a time through the single compare and add unit,
// then uses the store port (a word read uses it twice), then raises the result
// strobe
// a table load or unused op goes straight to the strobe; the result cannot be stalled
// ----------------------------------------------------------------------------
module segment_remapped_eeprom_store_unit #(
  parameter int MEM_BYTES    = sres_pkg::MEM_BYTES_DEF,
  parameter int MAX_SEGMENTS = sres_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  sres_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output sres_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sres_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sres_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW     = $clog2(MAX_SEGMENTS + 1);
  localparam logic [16:0] MEM_LIM = 17'(MEM_BYTES);

  sres_pkg::state_t    state_r, state_nxt;
  logic [MEM_AW-1:0]   clr_r, clr_nxt;
  logic                translate_r, translate_nxt;
  logic [8:0]          count_r, count_nxt;
  sres_pkg::op_t       op_r, op_nxt;
  logic [15:0]         addr_r, addr_nxt;
  logic [15:0]         wdata_r, wdata_nxt;
  logic [CW-1:0]       lim_r, lim_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [16:0]         t_r, t_nxt;
  logic [15:0]         rdata_r, rdata_nxt;
  logic                status_r, status_nxt;

  sres_pkg::seg_t      seg_mem [MAX_SEGMENTS];
  sres_pkg::seg_t      seg_q;
  sres_pkg::seg_t      seg_wdata;
  logic                seg_we;
  logic [SEG_AW-1:0]   seg_waddr;
  logic [SEG_AW-1:0]   seg_raddr;

  logic [7:0]          mem [MEM_BYTES];
  logic [7:0]          mem_q;
  logic [7:0]          mem_wdata;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_addr;

  logic                accept;
  logic                is_access;
  logic                is_word;
  logic                load_ok;
  logic [CW-1:0]       lim_calc;
  logic [16:0]         diff;
  logic                walk_below;
  logic                walk_hit;
  logic                walk_last;
  logic [16:0]         walk_target;
  logic [16:0]         t_plus1;
  logic                rng_ok;

  assign accept    = start && !busy;
  assign is_access = (in_data.op == sres_pkg::OP_RD_BYTE) ||
                     (in_data.op == sres_pkg::OP_RD_WORD) ||
                     (in_data.op == sres_pkg::OP_WR_BYTE) ||
                     (in_data.op == sres_pkg::OP_WR_WORD);
  assign load_ok   = int'(in_data.entry_index) < MAX_SEGMENTS;
  assign lim_calc  = (int'(count_r) > MAX_SEGMENTS) ? CW'(MAX_SEGMENTS) : CW'(count_r);

  // shared compare and add unit for the table walk
  assign diff        = {1'b0, addr_r} - {1'b0, seg_q.src};
  assign walk_below  = diff[16];
  assign walk_hit    = !walk_below && (diff[15:0] < seg_q.len);
  assign walk_target = {1'b0, seg_q.dst} + {1'b0, diff[15:0]};
  assign walk_last   = (idx_r + CW'(1)) == lim_r;

  assign is_word = (op_r == sres_pkg::OP_RD_WORD) || (op_r == sres_pkg::OP_WR_WORD);
  assign t_plus1 = t_r + 17'd1;
  assign rng_ok  = is_word ? (t_r < (MEM_LIM - 17'd1)) : (t_r < MEM_LIM);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sres_pkg::ST_CLEAR: begin
        if (clr_r == MEM_AW'(MEM_BYTES - 1)) state_nxt = sres_pkg::ST_IDLE;
      end
      sres_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_access) state_nxt = sres_pkg::ST_DONE;
          else if (!translate_r) state_nxt = sres_pkg::ST_ACCESS;
          else if (lim_calc == '0) state_nxt = sres_pkg::ST_DONE;
          else state_nxt = sres_pkg::ST_WALK;
        end
      end
      sres_pkg::ST_WALK: begin
        if (walk_below) state_nxt = sres_pkg::ST_DONE;
        else if (walk_hit) state_nxt = sres_pkg::ST_ACCESS;
        else if (walk_last) state_nxt = sres_pkg::ST_DONE;
      end
      sres_pkg::ST_ACCESS: begin
        if (!rng_ok) state_nxt = sres_pkg::ST_DONE;
        else begin
          case (op_r)
            sres_pkg::OP_RD_BYTE: state_nxt = sres_pkg::ST_RD0;
            sres_pkg::OP_RD_WORD: state_nxt = sres_pkg::ST_RD0;
            sres_pkg::OP_WR_WORD: state_nxt = sres_pkg::ST_WR1;
            default:              state_nxt = sres_pkg::ST_DONE;
          endcase
        end
      end
      sres_pkg::ST_RD0: begin
        state_nxt = is_word ? sres_pkg::ST_RD1 : sres_pkg::ST_DONE;
      end
      sres_pkg::ST_RD1: state_nxt = sres_pkg::ST_DONE;
      sres_pkg::ST_WR1: state_nxt = sres_pkg::ST_DONE;
      sres_pkg::ST_DONE: state_nxt = sres_pkg::ST_IDLE;
      default: state_nxt = sres_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory controls and outputs
  always_comb begin
    clr_nxt    = clr_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    wdata_nxt  = wdata_r;
    lim_nxt    = lim_r;
    idx_nxt    = idx_r;
    t_nxt      = t_r;
    rdata_nxt  = rdata_r;
    status_nxt = status_r;
    seg_we     = 1'b0;
    seg_waddr  = SEG_AW'(in_data.entry_index);
    seg_wdata  = '{src: in_data.entry_src_base, dst: in_data.entry_dst_base,
                   len: in_data.entry_len};
    mem_we     = 1'b0;
    mem_addr   = t_r[MEM_AW-1:0];
    mem_wdata  = wdata_r[7:0];

    translate_nxt = translate_r;
    count_nxt     = count_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sres_pkg::CFG_TRANSLATE_ENABLE: translate_nxt = cfg_wdata[0];
        sres_pkg::CFG_ENTRY_COUNT:      count_nxt     = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      sres_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = 8'hff;
        clr_nxt   = clr_r + MEM_AW'(1);
      end
      sres_pkg::ST_IDLE: begin
        // table read address must be entry zero when the walk starts
        idx_nxt = '0;
        if (accept) begin
          op_nxt     = in_data.op;
          addr_nxt   = in_data.addr;
          wdata_nxt  = in_data.wdata;
          lim_nxt    = lim_calc;
          t_nxt      = {1'b0, in_data.addr};
          rdata_nxt  = sres_pkg::fail_rdata(in_data.op);
          status_nxt = 1'b1;
          if (in_data.op == sres_pkg::OP_LOAD) begin
            seg_we     = load_ok;
            status_nxt = !load_ok;
          end
        end
      end
      sres_pkg::ST_WALK: begin
        idx_nxt = idx_r + CW'(1);
        if (walk_hit) t_nxt = walk_target;
      end
      sres_pkg::ST_ACCESS: begin
        if (rng_ok) begin
          status_nxt = 1'b0;
          if ((op_r == sres_pkg::OP_WR_BYTE) || (op_r == sres_pkg::OP_WR_WORD)) begin
            mem_we = 1'b1;
          end
        end
      end
      sres_pkg::ST_RD0: begin
        mem_addr  = t_plus1[MEM_AW-1:0];
        rdata_nxt = {8'h00, mem_q};
      end
      sres_pkg::ST_RD1: begin
        rdata_nxt[15:8] = mem_q;
      end
      sres_pkg::ST_WR1: begin
        mem_we    = 1'b1;
        mem_addr  = t_plus1[MEM_AW-1:0];
        mem_wdata = wdata_r[15:8];
      end
      default: ;
    endcase

    busy      = state_r != sres_pkg::ST_IDLE;
    out_valid = state_r == sres_pkg::ST_DONE;
    out_data  = '{rdata: rdata_r, status: status_r};
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sres_pkg::ST_CLEAR;
      clr_r       <= '0;
      translate_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      translate_r <= translate_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    lim_r    <= lim_nxt;
    idx_r    <= idx_nxt;
    t_r      <= t_nxt;
    rdata_r  <= rdata_nxt;
    status_r <= status_nxt;
  end

  // segment table, read one entry ahead of the walk
  assign seg_raddr = idx_nxt[SEG_AW-1:0];

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
    seg_q <= seg_mem[seg_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_q <= mem[mem_addr];
  end

`include "segment_remapped_eeprom_store_unit_assert.svh"

  `SRES_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
  `SRES_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid && !busy, "result strobe not single")
  `SRES_ASSERT_SAME(a_walk_bound, state_r == sres_pkg::ST_WALK, idx_r < lim_r, "walk past limit")
  `SRES_ASSERT_SAME(a_byte_upper, out_valid && (op_r == sres_pkg::OP_RD_BYTE), out_data.rdata[15:8] == 8'h00, "byte read upper bits set")

endmodule

[sim/segment_remapped_eeprom_store_unit_test.sv]
// ----------------------------------------------------------------------------
// segment_remapped_eeprom_store_unit_test
// self-checking bench for the remapped byte store: a command-level predictor
// tracks store, segment table and registers, every result strobe is checked
// ----------------------------------------------------------------------------
module segment_remapped_eeprom_store_unit_test;

  localparam int MEM          = sres_pkg::MEM_BYTES_DEF;
  localparam int MAX_SEG      = sres_pkg::MAX_SEGMENTS_DEF;
  localparam int RANDOM_ITEMS = 1400;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  sres_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  sres_pkg::out_item_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [sres_pkg::CFG_IDX_W-1:0]  cfg_index = sres_pkg::CFG_TRANSLATE_ENABLE;
  logic [sres_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  segment_remapped_eeprom_store_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [7:0]      store_bytes [MEM] = '{default: 8'hff};
  sres_pkg::seg_t  seg_tbl [MAX_SEG] = '{default: '0};
  logic            xlate_on = 1'b0;
  logic [8:0]      walk_count = '0;

  sres_pkg::out_item_t pending_replies [$];
  int          fail_count = 0;
  int          sent_items = 0;
  int          idle_pct = 11;
  int          n_reads = 0, n_writes = 0, n_loads = 0, n_refused = 0, n_remapped = 0;

  function automatic bit remap_address(input logic [15:0] a, output int unsigned tgt);
    int unsigned n;
    tgt = 0;
    if (!xlate_on) begin
      tgt = a;
      return 1'b1;
    end
    n = (walk_count > MAX_SEG) ? MAX_SEG : walk_count;
    for (int unsigned i = 0; i < n; i++) begin
      if (a < seg_tbl[i].src) return 1'b0;
      if (16'(a - seg_tbl[i].src) < seg_tbl[i].len) begin
        // 17-bit sum, no wrap
        tgt = 32'(seg_tbl[i].dst) + 32'(16'(a - seg_tbl[i].src));
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic sres_pkg::out_item_t model_step(input sres_pkg::in_item_t it);
    sres_pkg::out_item_t r;
    int unsigned t;
    bit          hit;
    r.rdata  = '0;
    r.status = 1'b1;
    if (xlate_on && it.op inside {sres_pkg::OP_RD_BYTE, sres_pkg::OP_RD_WORD,
                                  sres_pkg::OP_WR_BYTE, sres_pkg::OP_WR_WORD})
      n_remapped++;
    case (it.op)
      sres_pkg::OP_RD_BYTE: begin
        n_reads++;
        hit = remap_address(it.addr, t);
        if (hit && t < MEM) begin
          r.rdata  = {8'h00, store_bytes[t]};
          r.status = 1'b0;
        end else begin
          r.rdata = 16'h00ff;
        end
      end
      sres_pkg::OP_RD_WORD: begin
        n_reads++;
        hit = remap_address(it.addr, t);
        if (hit && t + 1 < MEM) begin
          r.rdata  = {store_bytes[t + 1], store_bytes[t]};
          r.status = 1'b0;
        end else begin
          r.rdata = 16'hffff;
        end
      end
      sres_pkg::OP_WR_BYTE: begin
        n_writes++;
        hit = remap_address(it.addr, t);
        if (hit && t < MEM) begin
          store_bytes[t] = it.wdata[7:0];
          r.status = 1'b0;
        end
      end
      sres_pkg::OP_WR_WORD: begin
        n_writes++;
        hit = remap_address(it.addr, t);
        if (hit && t + 1 < MEM) begin
          store_bytes[t]     = it.wdata[7:0];
          store_bytes[t + 1] = it.wdata[15:8];
          r.status = 1'b0;
        end
      end
      sres_pkg::OP_LOAD: begin
        n_loads++;
        if (int'(it.entry_index) < MAX_SEG) begin
          seg_tbl[it.entry_index] = '{src: it.entry_src_base, dst: it.entry_dst_base,
                                      len: it.entry_len};
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    if (r.status) n_refused++;
    return r;
  endfunction

  // every result strobe is matched against the oldest prediction
  always @(posedge clk) begin : reply_check
    sres_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result: rdata %h status %b", out_data.rdata, out_data.status);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_data.rdata !== want.rdata) begin
          $error("rdata: expected %h, got %h", want.rdata, out_data.rdata);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input sres_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    pending_replies.push_back(model_step(it));
    sent_items++;
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input sres_pkg::cfg_reg_t idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sres_pkg::CFG_TRANSLATE_ENABLE: xlate_on = val[0];
      sres_pkg::CFG_ENTRY_COUNT:      walk_count = val;
      default: ;
    endcase
  endtask

  // registers change only with the block idle
  task automatic set_mapping(input logic en, input logic [8:0] cnt);
    drain_replies();
    write_reg(sres_pkg::CFG_ENTRY_COUNT, cnt);
    write_reg(sres_pkg::CFG_TRANSLATE_ENABLE, {8'($urandom), en});
    cfg_valid <= 1'b0;
  endtask

  function automatic sres_pkg::in_item_t random_item();
    sres_pkg::in_item_t it;
    it.op             = sres_pkg::op_t'(3'($urandom_range(sres_pkg::OP_LOAD)));
    it.addr           = 16'($urandom);
    it.wdata          = 16'($urandom);
    it.entry_index    = 8'($urandom);
    it.entry_src_base = 16'($urandom);
    it.entry_dst_base = 16'($urandom);
    it.entry_len      = 16'($urandom);
    return it;
  endfunction

  function automatic sres_pkg::in_item_t make_access(input sres_pkg::op_t op,
                                                     input logic [15:0] a,
                                                     input logic [15:0] d);
    sres_pkg::in_item_t it;
    it       = random_item();
    it.op    = op;
    it.addr  = a;
    it.wdata = d;
    return it;
  endfunction

  function automatic sres_pkg::in_item_t make_load(input logic [7:0] idx,
                                                   input logic [15:0] src,
                                                   input logic [15:0] dst,
                                                   input logic [15:0] len);
    sres_pkg::in_item_t it;
    it                = random_item();
    it.op             = sres_pkg::OP_LOAD;
    it.entry_index    = idx;
    it.entry_src_base = src;
    it.entry_dst_base = dst;
    it.entry_len      = len;
    return it;
  endfunction

  // random access, mostly aimed inside a segment that the walk can reach
  function automatic sres_pkg::in_item_t access_item();
    sres_pkg::in_item_t it;
    int             roll;
    int             lim;
    int             span;
    sres_pkg::seg_t s;
    int unsigned    off;
    it   = random_item();
    roll = $urandom_range(99);
    if (roll < 24)      it.op = sres_pkg::OP_RD_BYTE;
    else if (roll < 46) it.op = sres_pkg::OP_RD_WORD;
    else if (roll < 68) it.op = sres_pkg::OP_WR_BYTE;
    else if (roll < 90) it.op = sres_pkg::OP_WR_WORD;
    else if (roll < 96) it.op = sres_pkg::OP_LOAD;
    else it.op = sres_pkg::op_t'(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)));
    lim = (walk_count > MAX_SEG) ? MAX_SEG : int'(walk_count);
    if (xlate_on && lim > 0 && $urandom_range(99) < 75) begin
      s = seg_tbl[$urandom_range(lim - 1)];
      span = int'(s.len) - 1;
      if (span < 0)               off = 0;
      else if ($urandom_range(1)) off = $urandom_range(span);
      else                        off = $urandom_range(span < 63 ? span : 63);
      it.addr = 16'(32'(s.src) + off);
    end else if (!xlate_on && $urandom_range(99) < 85) begin
      it.addr = 16'($urandom_range(MEM + 63));
    end
    return it;
  endfunction

  // loads entries 0..n-1 in ascending source order, now and then with two swapped
  task automatic load_sorted_table(input int n);
    sres_pkg::seg_t plan [$];
    sres_pkg::seg_t s;
    sres_pkg::seg_t tmp;
    int   span;
    int   r;
    int   a;
    int   b;
    span = 65536 / n;
    for (int i = 0; i < n; i++) begin
      s.src = 16'(i * span + $urandom_range(span / 4));
      r = $urandom_range(9);
      if (r == 0)     s.len = '0;
      else if (r < 7) s.len = 16'($urandom_range(span - span / 4, 1));
      else            s.len = 16'($urandom_range(65535, 1));
      r = $urandom_range(99);
      if (r < 75)      s.dst = 16'($urandom_range(MEM - 1));
      else if (r < 85) s.dst = 16'($urandom_range(MEM - 1, MEM - 64));
      else             s.dst = 16'($urandom);
      plan.push_back(s);
    end
    if (n > 1 && $urandom_range(9) == 0) begin
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      tmp     = plan[a];
      plan[a] = plan[b];
      plan[b] = tmp;
    end
    for (int i = 0; i < n; i++)
      send_item(make_load(8'(i), plan[i].src, plan[i].dst, plan[i].len));
  endtask

  // direct addressing: erased store, byte and word ends of the store, unused ops
  task automatic test_plain_access();
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'h0000, 16'h1234));
    send_item(make_access(sres_pkg::OP_WR_BYTE, 16'h0000, 16'h5aa5));
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'h0000, 16'h0000));
    send_item(make_access(sres_pkg::OP_WR_WORD, 16'(MEM - 2), 16'hbeef));
    send_item(make_access(sres_pkg::OP_RD_WORD, 16'(MEM - 2), 16'hffff));
    send_item(make_access(sres_pkg::OP_WR_WORD, 16'(MEM - 1), 16'h1357));
    send_item(make_access(sres_pkg::OP_RD_WORD, 16'(MEM - 1), 16'h0000));
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'(MEM - 1), 16'h0000));
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'(MEM), 16'h0000));
    send_item(make_access(sres_pkg::OP_WR_BYTE, 16'hffff, 16'hffff));
    send_item(make_access(sres_pkg::OP_RD_WORD, 16'hffff, 16'h0000));
    for (int k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++)
      send_item(make_access(sres_pkg::op_t'(3'(k)), 16'h0000, 16'hffff));
  endtask

  // table walk: below a base, between entries, past every entry, target overflow
  task automatic test_remap_cases();
    send_item(make_load(8'd0, 16'h0100, 16'h0000, 16'h0010));
    send_item(make_load(8'd1, 16'h0200, 16'(MEM - 2), 16'h0100));
    send_item(make_load(8'd2, 16'hff00, 16'hffff, 16'hffff));
    send_item(make_load(8'd255, 16'hffff, 16'hffff, 16'hffff));
    set_mapping(1'b1, 9'd3);
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'h00ff, 16'h0000));
    send_item(make_access(sres_pkg::OP_WR_BYTE, 16'h0105, 16'h0011));
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'h0105, 16'h0000));
    send_item(make_access(sres_pkg::OP_WR_WORD, 16'h0200, 16'hc3a6));
    send_item(make_access(sres_pkg::OP_RD_WORD, 16'h0201, 16'h0000));
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'h0201, 16'h0000));
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'h0150, 16'h0000));
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'hffff, 16'h0000));
    send_item(make_access(sres_pkg::OP_RD_WORD, 16'h0300, 16'h0000));
    set_mapping(1'b1, 9'd0);
    send_item(make_access(sres_pkg::OP_RD_BYTE, 16'h0105, 16'h0000));
    set_mapping(1'b1, 9'd2);
    send_item(make_access(sres_pkg::OP_RD_WORD, 16'h8000, 16'h0000));
  endtask

  // every slot written, then the longest walks, count at and beyond the table
  task automatic test_full_table();
    idle_pct = 0;
    set_mapping(1'b0, 9'd0);
    load_sorted_table(MAX_SEG);
    set_mapping(1'b1, 9'(MAX_SEG));
    repeat (30) send_item(access_item());
    set_mapping(1'b1, 9'h1ff);
    repeat (30) send_item(access_item());
  endtask

  task automatic test_random_traffic();
    int base;
    int roll;
    int n;
    int burst;
    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      // the opening stretch runs without sender gaps
      idle_pct = (sent_items - base < 300) ? 0 : 11;
      roll = $urandom_range(99);
      burst = $urandom_range(40, 10);
      if (roll < 15) begin
        set_mapping(1'b0, 9'($urandom_range(511)));
      end else if (roll < 25) begin
        set_mapping(1'b1, 9'($urandom_range(511, 200)));
        burst = $urandom_range(20, 5);
      end else begin
        n = (roll < 35) ? $urandom_range(48, 13) : $urandom_range(12, 1);
        set_mapping(xlate_on, walk_count);
        load_sorted_table(n);
        set_mapping(1'b1, 9'(n));
      end
      repeat (burst) send_item(access_item());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_access();
    test_remap_cases();
    test_full_table();
    test_random_traffic();
    drain_replies();
    repeat (MAX_SEG + 16) @(posedge clk);
    $display("ran %0d commands: %0d reads, %0d writes, %0d table loads",
             sent_items, n_reads, n_writes, n_loads);
    $display("%0d accesses went through the segment walk, %0d commands were refused",
             n_remapped, n_refused);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
